// ===== rtl/iee_pkg.sv =====
`default_nettype none
package iee_pkg;
  localparam int STACK_DEPTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_LPAR = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    K_DIGIT = 3'd0,
    K_OPER  = 3'd1,
    K_LPAR  = 3'd2,
    K_RPAR  = 3'd3,
    K_BAD   = 3'd4,
    K_FINAL = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIVZERO   = 2'd1,
    ST_DEEP      = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FLUSH, S_DECIDE, S_RD_OP, S_RD_A, S_RD_B, S_EXEC,
    S_DIV, S_PUSH, S_PUSHOP, S_FIN, S_FIN_RD, S_OUT
  } state_t;

  // classified symbol handed from front to back
  typedef struct packed {
    kind_t      kind;
    op_t        op;
    logic [3:0] digit;
  } tok_t;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_LP = 8'h28;
  localparam logic [7:0] CH_RP = 8'h29;
  localparam logic [7:0] CH_MUL = 8'h2a;
  localparam logic [7:0] CH_ADD = 8'h2b;
  localparam logic [7:0] CH_SUB = 8'h2d;
  localparam logic [7:0] CH_DIV = 8'h2f;

  function automatic logic prec_hi(op_t o);
    return (o == OP_MUL) || (o == OP_DIV);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/iee_front.sv =====
`default_nettype none
module iee_front import iee_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] symbol,
  input  wire logic       final_req,
  output logic            q_valid,
  input  wire logic       q_ready,
  output tok_t            q_tok
);
  // two-entry queue
  tok_t       buf_q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  tok_t       t;

  always_comb begin
    t.digit = symbol[3:0];
    t.op = OP_NONE;
    t.kind = K_BAD;
    if (final_req) t.kind = K_FINAL;
    else if (symbol >= CH_0 && symbol <= CH_9) t.kind = K_DIGIT;
    else begin
      case (symbol)
        CH_ADD: begin t.kind = K_OPER; t.op = OP_ADD; end
        CH_SUB: begin t.kind = K_OPER; t.op = OP_SUB; end
        CH_MUL: begin t.kind = K_OPER; t.op = OP_MUL; end
        CH_DIV: begin t.kind = K_OPER; t.op = OP_DIV; end
        CH_LP: t.kind = K_LPAR;
        CH_RP: t.kind = K_RPAR;
        default: t.kind = K_BAD;
      endcase
    end
  end

  assign in_ready = (cnt != 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_tok = buf_q[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) buf_q[wp] <= t;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/iee_div.sv =====
`default_nettype none
module iee_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      q
);
  // restoring divider on magnitudes, one quotient bit a cycle
  logic [31:0] rem, quo, dvs;
  logic [5:0]  n;
  logic        neg, busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};
  assign q = neg ? 32'd0 - quo : quo;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      n <= 6'd0;
      neg <= a[31] ^ b[31];
      quo <= a[31] ? 32'd0 - a : a;
      dvs <= b[31] ? 32'd0 - b : b;
      rem <= 32'd0;
    end else if (busy) begin
      if (!trial[32]) rem <= trial[31:0];
      else rem <= {rem[30:0], quo[31]};
      quo <= {quo[30:0], ~trial[32]};
      n <= n + 6'd1;
      if (n == 6'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/iee_back.sv =====
`default_nettype none
module iee_back import iee_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  output logic        q_ready,
  input  wire tok_t   q_tok,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [31:0] value,
  output logic [1:0]  status
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam logic [TW-1:0] FULL = TW'(STACK_DEPTH);

  logic [31:0] opnd_mem [STACK_DEPTH];
  logic [2:0]  optr_mem [STACK_DEPTH];

  state_t      state, state_next;
  tok_t        tok;
  logic [TW-1:0] otop, ptop;
  logic [31:0] acc, rb, res, rd_d;
  logic [2:0]  rd_op;
  op_t         cur_op;
  logic        nact, expo;
  logic [1:0]  err;
  logic        div_start, div_done;
  logic [31:0] div_q;

  // left operand is the registered read of the new top during S_EXEC
  iee_div u_div (.clk, .rst, .start(div_start), .a(rd_d), .b(rb),
                 .done(div_done), .q(div_q));

  assign q_ready = (state == S_IDLE) && !out_valid;

  // whether the current token wants another reduction on the stacked top
  logic reduce_more;
  always_comb begin
    reduce_more = 1'b0;
    if (ptop != '0 && op_t'(rd_op) != OP_LPAR) begin
      case (tok.kind)
        K_OPER:  reduce_more = prec_hi(op_t'(rd_op)) || !prec_hi(tok.op);
        K_RPAR,
        K_FINAL: reduce_more = 1'b1;
        default: reduce_more = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    case (state)
      S_IDLE:  if (q_valid && !out_valid) state_next = S_FLUSH;
      S_FLUSH: begin
        if (tok.kind == K_FINAL) state_next = S_RD_OP;
        else if (err != ST_OK || tok.kind == K_DIGIT) state_next = S_IDLE;
        else state_next = S_RD_OP;
      end
      S_RD_OP: state_next = S_DECIDE;
      S_DECIDE: begin
        if (err != ST_OK) state_next = (tok.kind == K_FINAL) ? S_FIN_RD : S_IDLE;
        else if (reduce_more) state_next = S_RD_A;
        else if (tok.kind == K_FINAL) state_next = S_FIN_RD;
        else if (tok.kind == K_RPAR) state_next = S_IDLE;
        else state_next = S_PUSHOP;
      end
      S_RD_A:  state_next = (otop < TW'(2)) ? S_RD_OP : S_RD_B;
      S_RD_B:  state_next = S_EXEC;
      S_EXEC: begin
        if (cur_op == OP_DIV && rb != 32'd0) begin
          div_start = 1'b1;
          state_next = S_DIV;
        end else state_next = S_PUSH;
      end
      S_DIV:    if (div_done) state_next = S_PUSH;
      S_PUSH:   state_next = S_RD_OP;
      S_PUSHOP: state_next = S_IDLE;
      S_FIN_RD: state_next = S_FIN;
      S_FIN:    state_next = S_OUT;
      S_OUT:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_op <= optr_mem[AW'(ptop - TW'(1))];
    rd_d  <= opnd_mem[AW'(otop - TW'(1))];
    case (state)
      S_RD_A: begin
        rb <= rd_d;
        cur_op <= op_t'(rd_op);
      end
      default: ;
    endcase
    if (state == S_EXEC) begin
      case (cur_op)
        OP_ADD:  res <= rd_d + rb;
        OP_SUB:  res <= rd_d - rb;
        OP_MUL:  res <= rd_d * rb;
        default: res <= 32'd0;
      endcase
    end
    if (state == S_DIV && div_done) res <= div_q;
    if (state == S_FLUSH && nact && err == ST_OK && tok.kind != K_DIGIT && otop != FULL)
      opnd_mem[AW'(otop)] <= acc;
    if (state == S_PUSH && otop != FULL) opnd_mem[AW'(otop)] <= res;
    if (state == S_PUSHOP && ptop != FULL)
      optr_mem[AW'(ptop)] <= (tok.kind == K_LPAR) ? OP_LPAR : tok.op;
    if (state == S_FIN) value <= (err == ST_OK && otop == TW'(1)) ? rd_d : 32'd0;
    if (state == S_IDLE && q_valid && !out_valid) tok <= q_tok;
    if (state == S_RD_A && otop >= TW'(2)) otop <= otop - TW'(1);
    if (state == S_RD_B) otop <= otop - TW'(1);

    if (rst) begin
      state <= S_IDLE;
      otop <= '0; ptop <= '0; acc <= 32'd0; nact <= 1'b0; expo <= 1'b1;
      err <= ST_OK; out_valid <= 1'b0; status <= ST_OK;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_FLUSH: begin
          if (tok.kind == K_DIGIT) begin
            if (err == ST_OK) begin
              if (nact) acc <= (acc << 3) + (acc << 1) + 32'(tok.digit);
              else if (expo) begin
                nact <= 1'b1; acc <= 32'(tok.digit); expo <= 1'b0;
              end else err <= ST_MALFORMED;
            end
          end else if (err == ST_OK) begin
            if (nact) begin
              nact <= 1'b0; acc <= 32'd0;
              if (otop == FULL) err <= ST_DEEP;
              else otop <= otop + TW'(1);
            end
            case (tok.kind)
              K_OPER, K_RPAR: if (expo) err <= ST_MALFORMED;
              K_LPAR: if (!expo) err <= ST_MALFORMED;
              K_FINAL: if (expo) err <= ST_MALFORMED;
              default: err <= ST_MALFORMED;
            endcase
          end
        end
        S_DECIDE: if (err == ST_OK && !reduce_more) begin
          if (tok.kind == K_RPAR) begin
            if (ptop == '0) err <= ST_MALFORMED;
            else ptop <= ptop - TW'(1);
          end else if (tok.kind == K_FINAL && ptop != '0) err <= ST_MALFORMED;
        end
        S_RD_A: begin
          ptop <= ptop - TW'(1);
          if (otop < TW'(2)) err <= ST_MALFORMED;
        end
        S_EXEC: begin
          if (cur_op == OP_DIV && rb == 32'd0) begin
            err <= ST_DIVZERO;
            res <= 32'd0;
          end
        end
        S_PUSH: begin
          if (otop == FULL) begin
            if (err == ST_OK) err <= ST_DEEP;
          end else otop <= otop + TW'(1);
        end
        S_PUSHOP: begin
          if (ptop == FULL) err <= ST_DEEP;
          else ptop <= ptop + TW'(1);
          if (tok.kind == K_OPER) expo <= 1'b1;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          status <= (err == ST_OK && otop != TW'(1)) ? ST_MALFORMED : err;
          otop <= '0; ptop <= '0; acc <= 32'd0; nact <= 1'b0; expo <= 1'b1;
          err <= ST_OK;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) otop <= FULL)
    else $error("operand top beyond depth");
  assert property (@(posedge clk) disable iff (rst) ptop <= FULL)
    else $error("operator top beyond depth");
  assert property (@(posedge clk) disable iff (rst) q_ready |-> state == S_IDLE)
    else $error("token taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> value == 32'd0)
    else $error("value not cleared on error");
endmodule
`default_nettype wire

// ===== rtl/infix_integer_expression_evaluator.sv =====
// Flow: each symbol passes through the back end in turn; every reduction adds
// states of its own, and each division also waits on the bit-serial divider;
// the final symbol runs its reductions before the result is offered.
// Throughput: one symbol at a time through the back end; a 2-entry queue
// lets the front take symbols while the back end reduces.
// Reset: synchronous, active high; clears stack tops, flags and queue.
`default_nettype none
module infix_integer_expression_evaluator import iee_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // symbol[7:0]
  input  wire logic        s_axis_tuser,  // final_req
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // value[31:0], status[33:32], zero pad
);
  logic q_valid, q_ready;
  tok_t q_tok;
  logic [31:0] value;
  logic [1:0]  status;

  iee_front u_front (.clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .symbol(s_axis_tdata), .final_req(s_axis_tuser), .q_valid, .q_ready, .q_tok);

  iee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (.clk, .rst, .q_valid, .q_ready,
    .q_tok, .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .value, .status);

  assign m_axis_tdata = {6'd0, status, value};
endmodule
`default_nettype wire

// ===== dv/infix_integer_expression_evaluator_test.sv =====
`timescale 1ns / 1ps
module infix_integer_expression_evaluator_test;
  import iee_pkg::*;

  typedef struct {
    logic [31:0] value;
    status_t     status;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // symbol[7:0]
  logic        s_axis_tuser = 1'b0;   // final_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;          // value[31:0], status[33:32], zero pad

  localparam int DEPTH = STACK_DEPTH_DEF;

  infix_integer_expression_evaluator u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // evaluator state
  logic [31:0] num_stk [DEPTH];
  op_t         opr_stk [DEPTH];
  int          num_sp, opr_sp;
  logic [31:0] accum;
  logic        in_number, want_operand;
  status_t     err;

  answer_t answers [$];
  int      fails;
  bit      hold_off;

  function automatic void clear_eval();
    num_sp = 0; opr_sp = 0; accum = '0;
    in_number = 1'b0; want_operand = 1'b1; err = ST_OK;
  endfunction

  function automatic void raise(status_t c);
    if (err == ST_OK) err = c;
  endfunction

  function automatic void push_num(logic [31:0] v);
    if (num_sp >= DEPTH) raise(ST_DEEP);
    else begin
      num_stk[num_sp] = v;
      num_sp++;
    end
  endfunction

  function automatic void push_opr(op_t o);
    if (opr_sp >= DEPTH) raise(ST_DEEP);
    else begin
      opr_stk[opr_sp] = o;
      opr_sp++;
    end
  endfunction

  function automatic bit is_hi(op_t o);
    return o == OP_MUL || o == OP_DIV;
  endfunction

  function automatic void apply_top();
    op_t o;
    logic [31:0] a, b, r, ma, mb, q;
    opr_sp--;
    o = opr_stk[opr_sp];
    if (num_sp < 2) begin
      raise(ST_MALFORMED);
      return;
    end
    b = num_stk[num_sp-1];
    a = num_stk[num_sp-2];
    num_sp -= 2;
    case (o)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      default: begin
        if (b == 32'd0) begin
          raise(ST_DIVZERO);
          r = 32'd0;
        end else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb;
          r = (a[31] != b[31]) ? -q : q;
        end
      end
    endcase
    push_num(r);
  endfunction

  function automatic void close_number();
    if (in_number) begin
      in_number = 1'b0;
      push_num(accum);
      accum = '0;
    end
  endfunction

  function automatic void eval_symbol(logic [7:0] c);
    op_t o;
    o = OP_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      if (in_number) accum = accum * 32'd10 + 32'(c - CH_0);
      else if (want_operand) begin
        in_number = 1'b1;
        accum = 32'(c - CH_0);
        want_operand = 1'b0;
      end else raise(ST_MALFORMED);
      return;
    end
    close_number();
    if (err != ST_OK) return;
    case (c)
      CH_ADD: o = OP_ADD;
      CH_SUB: o = OP_SUB;
      CH_MUL: o = OP_MUL;
      CH_DIV: o = OP_DIV;
      default: o = OP_NONE;
    endcase
    if (o != OP_NONE) begin
      if (want_operand) begin
        raise(ST_MALFORMED);
        return;
      end
      while (err == ST_OK && opr_sp > 0 && opr_stk[opr_sp-1] != OP_LPAR &&
             (is_hi(opr_stk[opr_sp-1]) || !is_hi(o)))
        apply_top();
      push_opr(o);
      want_operand = 1'b1;
    end else if (c == CH_LP) begin
      if (!want_operand) begin
        raise(ST_MALFORMED);
        return;
      end
      push_opr(OP_LPAR);
    end else if (c == CH_RP) begin
      if (want_operand) begin
        raise(ST_MALFORMED);
        return;
      end
      while (err == ST_OK && opr_sp > 0 && opr_stk[opr_sp-1] != OP_LPAR)
        apply_top();
      if (err != ST_OK) return;
      if (opr_sp == 0) begin
        raise(ST_MALFORMED);
        return;
      end
      opr_sp--;
    end else raise(ST_MALFORMED);
  endfunction

  function automatic void eval_final();
    answer_t ans;
    if (err == ST_OK) begin
      close_number();
      if (want_operand) raise(ST_MALFORMED);
    end
    while (err == ST_OK && opr_sp > 0) begin
      if (opr_stk[opr_sp-1] == OP_LPAR) raise(ST_MALFORMED);
      else apply_top();
    end
    if (err == ST_OK && num_sp != 1) raise(ST_MALFORMED);
    ans.value = (err == ST_OK) ? num_stk[0] : 32'd0;
    ans.status = err;
    answers.push_back(ans);
    clear_eval();
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // tvalid stays up between back-to-back transactions and drops only for a gap
  task automatic send_symbol(logic [7:0] c, logic fin);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (fin) eval_final();
    else if (err == ST_OK) eval_symbol(c);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_symbol(s[i], 1'b0);
    send_symbol(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // receiver with random back-pressure and one long hold-off
  always @(posedge clk) begin
    answer_t e;
    if (rst) m_axis_tready <= 1'b0;
    else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers.size() == 0) begin
          $error("result with nothing outstanding: %h", m_axis_tdata);
          fails++;
        end else begin
          e = answers.pop_front();
          if (m_axis_tdata[31:0] !== e.value) begin
            $error("value expected %h actual %h", e.value, m_axis_tdata[31:0]);
            fails++;
          end
          if (m_axis_tdata[33:32] !== e.status) begin
            $error("status expected %0d actual %0d", e.status, m_axis_tdata[33:32]);
            fails++;
          end
        end
      end
      m_axis_tready <= hold_off ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  function automatic string rand_number();
    string s;
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 3);
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_0 + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_expr(int lvl);
    string s, ops;
    int n;
    ops = "+-*/";
    n = $urandom_range(1, 4);
    s = "";
    for (int i = 0; i < n; i++) begin
      if (i > 0) s = {s, string'(ops[$urandom_range(0, 3)])};
      if (lvl < 3 && $urandom_range(0, 3) == 0) s = {s, "(", rand_expr(lvl + 1), ")"};
      else s = {s, rand_number()};
    end
    return s;
  endfunction

  task automatic test_directed();
    string deep;
    send_text("1+2*3");
    send_text("(1+2)*3");
    send_text("7-3-2");
    send_text("100/7/2");
    send_text("0-7/2");
    send_text("4294967295");
    send_text("0-2147483647-1");
    send_text("(0-2147483647-1)/(0-1)");
    send_text("65536*65536+9");
    send_text("5/0");
    send_text("-3");
    send_text("2+");
    send_text("");
    send_text("(1+2");
    send_text("1+2)");
    send_text("3(4)");
    send_text("(2)5");
    send_text("1 +2");
    send_text("1+*2");
    send_text("5/(3-3)+x");
    deep = "";
    repeat (DEPTH + 1) deep = {deep, "("};
    send_text({deep, "1"});
    deep = "1";
    repeat (DEPTH + 1) deep = {deep, "+(1"};
    send_text(deep);
    send_text("8/3*3");
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h00, 1'b1);
  endtask

  task automatic test_random();
    string s;
    int sent, k, p;
    sent = 0;
    while (sent < 110) begin
      s = rand_expr(0);
      p = $urandom_range(0, 9);
      if (p == 0) begin
        k = $urandom_range(0, s.len());
        s = {s.substr(0, k - 1), string'(8'($urandom_range(0, 255))),
             s.substr(k, s.len() - 1)};
      end else if (p == 1 && s.len() > 1) s = s.substr(0, s.len() - 2);
      sent += s.len() + 1;
      send_text(s);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (12) send_text("1+2");
    join
  endtask

  initial begin
    fails = 0;
    hold_off = 1'b0;
    clear_eval();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("infix_integer_expression_evaluator_test passed");
    else $display("infix_integer_expression_evaluator_test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("infix_integer_expression_evaluator_test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/iee_pkg.sv
rtl/iee_front.sv
rtl/iee_div.sv
rtl/iee_back.sv
rtl/infix_integer_expression_evaluator.sv
dv/infix_integer_expression_evaluator_test.sv
